@@ hdl/binary_contour_extract_core_defines.svh @@
// assertion helpers used by the checker file
`ifndef BINARY_CONTOUR_EXTRACT_CORE_DEFINES_SVH
`define BINARY_CONTOUR_EXTRACT_CORE_DEFINES_SVH

// property checked at every edge outside reset
`define BCE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define BCE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bce_pkg.sv @@
package bce_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int MAX_ROWS  = 4096;

  localparam int LANE_W = 8;
  localparam int LANES  = (MAX_WIDTH + LANE_W - 1) / LANE_W;
  localparam int PAD_W  = LANES * LANE_W;

  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 2);
  localparam int CMP_W  = ((RIDX_W > 13) ? RIDX_W : 13) + 1;

  localparam int IMG_W_W    = 7;
  localparam int CONTOUR_W  = 64;
  localparam int WROW_W     = 12;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_PAD_W  = OUT_DATA_W - CONTOUR_W - WROW_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMG_WIDTH  = 3'd0,
    CFG_WIN_LEFT   = 3'd1,
    CFG_WIN_WIDTH  = 3'd2,
    CFG_WIN_TOP    = 3'd3,
    CFG_WIN_HEIGHT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [6:0]  img_width;
    logic [5:0]  win_left;
    logic [6:0]  win_width;
    logic [11:0] win_top;
    logic [12:0] win_height;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [WROW_W-1:0]    wrow;
    logic [CONTOUR_W-1:0] contour;
  } res_t;

endpackage

@@ hdl/bce_lane.sv @@
module bce_lane (
  input  logic [bce_pkg::LANE_W+1:0] above,
  input  logic [bce_pkg::LANE_W+1:0] mid,
  input  logic [bce_pkg::LANE_W+1:0] below,
  output logic [bce_pkg::LANE_W-1:0] edge_bits
);
  import bce_pkg::*;

  always_comb begin
    for (int i = 0; i < LANE_W; i++) begin
      edge_bits[i] = mid[i+1] & ~(above[i] & above[i+1] & above[i+2]
                                 & mid[i] & mid[i+2]
                                 & below[i] & below[i+1] & below[i+2]);
    end
  end

endmodule

@@ hdl/bce_merge.sv @@
module bce_merge (
  input  logic [bce_pkg::MAX_WIDTH-1:0] edge_bits,
  input  logic                          en,
  input  logic [bce_pkg::RIDX_W-1:0]    r,
  input  logic                          img_last,
  input  bce_pkg::cfg_t                 cfg,
  input  logic [bce_pkg::IMG_W_W-1:0]   eff_w,
  output bce_pkg::res_t                 res
);
  import bce_pkg::*;

  logic [7:0]           wend_raw;
  logic [7:0]           wend;
  logic [7:0]           span;
  logic [6:0]           n;
  logic                 col_ok;
  logic [MAX_WIDTH-1:0] shifted;
  logic [MAX_WIDTH-1:0] n_mask;
  logic [CMP_W-1:0]     top_e;
  logic [CMP_W-1:0]     bot;
  logic [CMP_W-1:0]     r_e;
  logic [CMP_W-1:0]     last_r;
  logic [CMP_W-1:0]     diff;
  logic                 row_ok;

  always_comb begin
    wend_raw = {2'b00, cfg.win_left} + {1'b0, cfg.win_width};
    wend     = (wend_raw > {1'b0, eff_w}) ? {1'b0, eff_w} : wend_raw;
    col_ok   = {2'b00, cfg.win_left} < wend;
    span     = wend - {2'b00, cfg.win_left};
    n        = span[6:0];

    shifted = edge_bits >> cfg.win_left;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      n_mask[c] = 7'(c) < n;
    end

    top_e  = CMP_W'(cfg.win_top);
    bot    = top_e + CMP_W'(cfg.win_height);
    r_e    = CMP_W'(r);
    last_r = bot - CMP_W'(1);
    diff   = r_e - top_e;
    row_ok = (r_e >= top_e) && (r_e < bot);

    res         = '0;
    res.valid   = en & col_ok & row_ok;
    res.last    = img_last || (r_e == last_r) || (r == RIDX_W'(MAX_ROWS - 1));
    res.wrow    = diff[WROW_W-1:0];
    res.contour[MAX_WIDTH-1:0] = shifted & n_mask;
  end

endmodule

@@ hdl/bce_outq.sv @@
module bce_outq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  bce_pkg::res_t                    res_a,
  input  bce_pkg::res_t                    res_b,
  output logic                             in_ready,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bce_pkg::OUT_DATA_W-1:0]   m_tdata,  // contour_bits, window_row, zero pad
  output logic                             m_tlast
);
  import bce_pkg::*;

  res_t       q [3];
  res_t       q_next [3];
  res_t       sh [3];
  res_t       p0;
  res_t       p1;
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] base;
  logic [1:0] npush;
  logic       pop;

  assign in_ready = count <= 2'd1;
  assign m_tvalid = count != 2'd0;
  assign pop      = m_tvalid & m_tready;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, q[0].wrow, q[0].contour};
  assign m_tlast  = q[0].last;

  always_comb begin
    base  = count - {1'b0, pop};
    npush = 2'd0;
    if (push) begin
      npush = {1'b0, res_a.valid} + {1'b0, res_b.valid};
    end
    p0 = res_a.valid ? res_a : res_b;
    p1 = res_b;

    sh[0] = pop ? q[1] : q[0];
    sh[1] = pop ? q[2] : q[1];
    sh[2] = q[2];

    for (int j = 0; j < 3; j++) begin
      q_next[j] = sh[j];
      if (npush != 2'd0 && 2'(j) == base) begin
        q_next[j] = p0;
      end
      if (npush == 2'd2 && 3'(j) == ({1'b0, base} + 3'd1)) begin
        q_next[j] = p1;
      end
    end
    count_next = base + npush;
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

endmodule

@@ hdl/binary_contour_extract_core.sv @@
// each result beat is written into the registered output queue when its row beat is taken
// throughput: one row per cycle while s_tready is high; a last row can yield two result beats,
// and s_tready drops while the three-entry output queue holds two or more
// all 64 pixel columns are checked combinationally by two sets of eight 8-column lanes
// reset (rst, synchronous, active high) restores the register defaults and clears the
// stored rows, the row counter and the output queue; no clearing pass is needed
module binary_contour_extract_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [bce_pkg::IN_DATA_W-1:0]    s_tdata,   // row_bits
  input  logic                             s_tlast,   // last_row
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bce_pkg::OUT_DATA_W-1:0]   m_tdata,   // contour_bits, window_row, zero pad
  output logic                             m_tlast,   // last
  input  logic                             cfg_we,
  input  logic [bce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bce_pkg::*;

  cfg_t                 cfg;
  logic [MAX_WIDTH-1:0] older;
  logic [MAX_WIDTH-1:0] middle;
  logic [CNT_W-1:0]     row_count;
  logic                 done_flag;

  logic [IMG_W_W-1:0]   eff_w;
  logic [MAX_WIDTH-1:0] w_mask;
  logic [MAX_WIDTH-1:0] cur_row;
  logic [MAX_WIDTH-1:0] old_eff;
  logic [MAX_WIDTH-1:0] mid_eff;
  logic [CNT_W-1:0]     cur;
  logic [CNT_W-1:0]     cur_m1;
  logic [CNT_W-1:0]     row_count_next;
  logic [PAD_W+1:0]     pad_old;
  logic [PAD_W+1:0]     pad_mid;
  logic [PAD_W+1:0]     pad_cur;
  logic [PAD_W-1:0]     edge_a;
  logic [PAD_W-1:0]     edge_b;
  logic                 en_a;
  logic                 en_b;
  logic                 accept;
  res_t                 res_a;
  res_t                 res_b;

  assign accept = s_tvalid & s_tready;

  always_comb begin
    eff_w = (cfg.img_width > IMG_W_W'(MAX_WIDTH)) ? IMG_W_W'(MAX_WIDTH) : cfg.img_width;
    for (int c = 0; c < MAX_WIDTH; c++) begin
      w_mask[c] = IMG_W_W'(c) < eff_w;
    end
    cur_row = s_tdata[MAX_WIDTH-1:0] & w_mask;
    old_eff = done_flag ? '0 : (older & w_mask);
    mid_eff = done_flag ? '0 : (middle & w_mask);
    cur     = done_flag ? '0 : row_count;
    cur_m1  = cur - CNT_W'(1);

    pad_old = '0;
    pad_mid = '0;
    pad_cur = '0;
    pad_old[MAX_WIDTH:1] = old_eff;
    pad_mid[MAX_WIDTH:1] = mid_eff;
    pad_cur[MAX_WIDTH:1] = cur_row;

    en_a = (cur >= CNT_W'(1)) && (cur <= CNT_W'(MAX_ROWS));
    en_b = s_tlast && (cur < CNT_W'(MAX_ROWS));

    row_count_next = (cur >= CNT_W'(MAX_ROWS + 1)) ? CNT_W'(MAX_ROWS + 1)
                                                   : cur + CNT_W'(1);
  end

  // lanes for the row above the new one, and for the new row when it ends the image
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bce_lane u_lane_a (
      .above     (pad_old[g*LANE_W +: LANE_W+2]),
      .mid       (pad_mid[g*LANE_W +: LANE_W+2]),
      .below     (pad_cur[g*LANE_W +: LANE_W+2]),
      .edge_bits (edge_a[g*LANE_W +: LANE_W])
    );
    bce_lane u_lane_b (
      .above     (pad_mid[g*LANE_W +: LANE_W+2]),
      .mid       (pad_cur[g*LANE_W +: LANE_W+2]),
      .below     ((LANE_W+2)'(0)),
      .edge_bits (edge_b[g*LANE_W +: LANE_W])
    );
  end

  bce_merge u_merge_a (
    .edge_bits (edge_a[MAX_WIDTH-1:0]),
    .en        (en_a),
    .r         (cur_m1[RIDX_W-1:0]),
    .img_last  (1'b0),
    .cfg       (cfg),
    .eff_w     (eff_w),
    .res       (res_a)
  );

  bce_merge u_merge_b (
    .edge_bits (edge_b[MAX_WIDTH-1:0]),
    .en        (en_b),
    .r         (cur[RIDX_W-1:0]),
    .img_last  (1'b1),
    .cfg       (cfg),
    .eff_w     (eff_w),
    .res       (res_b)
  );

  bce_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .res_a    (res_a),
    .res_b    (res_b),
    .in_ready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.img_width  <= 7'd64;
      cfg.win_left   <= 6'd0;
      cfg.win_width  <= 7'd64;
      cfg.win_top    <= 12'd0;
      cfg.win_height <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMG_WIDTH:  cfg.img_width  <= cfg_data[6:0];
        CFG_WIN_LEFT:   cfg.win_left   <= cfg_data[5:0];
        CFG_WIN_WIDTH:  cfg.win_width  <= cfg_data[6:0];
        CFG_WIN_TOP:    cfg.win_top    <= cfg_data[11:0];
        CFG_WIN_HEIGHT: cfg.win_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older     <= '0;
      middle    <= '0;
      row_count <= '0;
      done_flag <= 1'b0;
    end else if (accept) begin
      older     <= mid_eff;
      middle    <= cur_row;
      row_count <= row_count_next;
      done_flag <= s_tlast;
    end
  end

endmodule

@@ hdl/bce_checker.sv @@
`include "binary_contour_extract_core_defines.svh"

module bce_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bce_pkg::OUT_DATA_W-1:0] m_tdata
);

  // output queue empty right after reset
  `BCE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result beat valid after reset")

  // input stalls only while results are waiting
  `BCE_ASSERT(a_stall_has_data, clk, rst, !s_tready |-> m_tvalid, "input stalled with no result")

  `BCE_ASSERT(a_valid_holds, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")

  `BCE_ASSERT(a_data_holds, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled beat changed")

endmodule

bind binary_contour_extract_core bce_checker u_bce_checker (.*);
